### hdl/hkt_pkg.sv
// hkt_pkg: shared constants, command codes and the queued word type
// for the held key tracker; no dependencies

package hkt_pkg;

  // held-key table size and slot index width
  localparam int HELD_SLOTS = 8;
  localparam int SLOT_W     = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

  // front to back queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // key code arithmetic
  localparam logic [7:0] CODE_OFFSET = 8'd8;
  localparam logic [7:0] NARROW_MASK = 8'h7f;
  localparam logic [7:0] FREE_CODE   = 8'hff;

  // input command codes
  localparam logic [1:0] CMD_DOWN   = 2'd0;
  localparam logic [1:0] CMD_UP     = 2'd1;
  localparam logic [1:0] CMD_ALL_UP = 2'd2;
  localparam logic [1:0] CMD_OTHER  = 2'd3;

  // work the back part carries out for one word
  typedef enum logic [1:0] {
    OP_PASS,
    OP_DOWN,
    OP_UP,
    OP_ALL_UP
  } op_t;

  // classified word as it travels through the queue
  typedef struct packed {
    op_t         op;
    logic [7:0]  code;
    logic        is_release;
    logic [31:0] event_time;
  } item_t;

  // queue status seen by the top level and the back part
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

### hdl/hkt_front.sv
// hkt_front: holds the tracking mode register, classifies each input word
// and forms its key code; depends on hkt_pkg

module hkt_front import hkt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        accept,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_key_value,
  input  logic [31:0] in_event_time,
  output logic        push,
  output item_t       push_item
);

  logic       tracking_mode_r;
  logic [7:0] raw;
  op_t        op;

  // tracking mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_mode_r <= 1'b1;
    end else if (cfg_we) begin
      tracking_mode_r <= cfg_wdata;
    end
  end

  // mask the raw value outside tracking mode
  assign raw = tracking_mode_r ? in_key_value : (in_key_value & NARROW_MASK);

  // decide the table operation
  always_comb begin
    op = OP_PASS;
    if (tracking_mode_r) begin
      unique case (in_command)
        CMD_DOWN:   op = OP_DOWN;
        CMD_UP:     op = OP_UP;
        CMD_ALL_UP: op = OP_ALL_UP;
        CMD_OTHER:  op = OP_PASS;
        default:    op = OP_PASS;
      endcase
    end
  end

  // word for the queue
  assign push                 = accept;
  assign push_item.op         = op;
  assign push_item.code       = raw + CODE_OFFSET;
  assign push_item.is_release = (in_command == CMD_UP);
  assign push_item.event_time = in_event_time;

endmodule

### hdl/hkt_queue.sv
// hkt_queue: short queue of classified words between front and back
// parts; depends on hkt_pkg

module hkt_queue import hkt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t status
);

  item_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push;
  logic               do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = entries_r[rd_ptr_r];

  // pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/hkt_back.sv
// hkt_back: held-key table and slot scan sequencer that carries out each
// queued word and drives the result strobe; depends on hkt_pkg

module hkt_back import hkt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_status_t   q_status,
  input  item_t       q_item,
  output logic        pop,
  output logic        out_strobe,
  output logic [7:0]  out_key_code,
  output logic        out_is_release,
  output logic [31:0] out_time_out,
  output logic        out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                state_r;
  item_t                 cur_r;
  logic [SLOT_W-1:0]     idx_r;
  logic [HELD_SLOTS-1:0] valid_r;
  logic [7:0]            keys_r [HELD_SLOTS];
  logic                  out_strobe_r;
  logic [7:0]            out_key_code_r;
  logic                  out_is_release_r;
  logic [31:0]           out_time_out_r;
  logic                  out_last_r;

  logic [HELD_SLOTS:0]   above;
  logic                  none_above;
  logic                  at_end;
  logic                  slot_valid;
  logic                  slot_match;

  // slot status at the scan index
  assign above      = {1'b0, valid_r} >> idx_r;
  assign none_above = (above[HELD_SLOTS:1] == '0);
  assign at_end     = (idx_r == SLOT_W'(HELD_SLOTS - 1));
  assign slot_valid = valid_r[idx_r];
  assign slot_match = slot_valid && (keys_r[idx_r] == cur_r.code);

  assign pop = (state_r == S_IDLE) && !q_status.empty;

  // sequencer, table and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_status.empty) begin
            cur_r   <= q_item;
            idx_r   <= '0;
            state_r <= (q_item.op == OP_PASS) ? S_EMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          unique case (cur_r.op)
            OP_DOWN: begin
              if (!slot_valid) begin
                valid_r[idx_r] <= 1'b1;
                keys_r[idx_r]  <= cur_r.code;
                state_r        <= S_EMIT;
              end else if (at_end) begin
                state_r <= S_EMIT;
              end else begin
                idx_r <= idx_r + 1'b1;
              end
            end
            OP_UP: begin
              if (slot_match) begin
                valid_r[idx_r] <= 1'b0;
                keys_r[idx_r]  <= FREE_CODE;
                state_r        <= S_EMIT;
              end else if (at_end) begin
                state_r <= S_EMIT;
              end else begin
                idx_r <= idx_r + 1'b1;
              end
            end
            OP_ALL_UP: begin
              if (slot_valid) begin
                out_strobe_r     <= 1'b1;
                out_key_code_r   <= keys_r[idx_r];
                out_is_release_r <= 1'b1;
                out_time_out_r   <= cur_r.event_time;
                out_last_r       <= none_above;
                valid_r[idx_r]   <= 1'b0;
                keys_r[idx_r]    <= FREE_CODE;
              end
              if (none_above || at_end) begin
                state_r <= S_IDLE;
              end else begin
                idx_r <= idx_r + 1'b1;
              end
            end
            default: begin
              state_r <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          out_strobe_r     <= 1'b1;
          out_key_code_r   <= cur_r.code;
          out_is_release_r <= cur_r.is_release;
          out_time_out_r   <= cur_r.event_time;
          out_last_r       <= 1'b1;
          state_r          <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_key_code   = out_key_code_r;
  assign out_is_release = out_is_release_r;
  assign out_time_out   = out_time_out_r;
  assign out_last       = out_last_r;

endmodule

### hdl/held_key_tracker.sv
// held_key_tracker: top level joining the classifying front, the word
// queue and the table back part; depends on hkt_pkg and its submodules
//
//   channel  ports                                      handshake
//   input    in_command, in_key_value, in_event_time    start && !busy
//   result   out_key_code, out_is_release,              out_strobe, one cycle
//            out_time_out, out_last
//   config   cfg_wdata (tracking_mode)                  cfg_we
//
// a word is taken into a two-word queue on the cycle it is accepted; busy is
// high only while that queue is full.
// the back part pops a word only while idle; a plain word then gives its
// result from the emit state, a key down or key up scans up to HELD_SLOTS
// slots before its result, and an all keys up scan gives one release per
// held slot, for up to HELD_SLOTS slots.
// reset clears the queue, the held-slot valid bits and sets tracking mode.
// results are never held back: the receiver takes every strobed result.

module held_key_tracker import hkt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_key_value,
  input  logic [31:0] in_event_time,
  output logic        out_strobe,
  output logic [7:0]  out_key_code,
  output logic        out_is_release,
  output logic [31:0] out_time_out,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic      accept;
  logic      push;
  item_t     push_item;
  logic      pop;
  item_t     pop_item;
  q_status_t q_status;

  assign busy   = q_status.full;
  assign accept = start && !busy;

  // classify incoming words
  hkt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .in_command    (in_command),
    .in_key_value  (in_key_value),
    .in_event_time (in_event_time),
    .push          (push),
    .push_item     (push_item)
  );

  // queue between the two parts
  hkt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // table scan and results
  hkt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_item         (pop_item),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_key_code   (out_key_code),
    .out_is_release (out_is_release),
    .out_time_out   (out_time_out),
    .out_last       (out_last)
  );

endmodule
